@@ rtl/tso_pkg.sv @@
// Shared types and constants for the trapezoid scroll offset block.
// Used by tso_serial and trapezoid_scroll_offset_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tso_pkg;

  localparam int FRAC_BITS = 16;

  // Shared serial unit sizing.
  localparam int OPA_W     = 32;
  localparam int OPB_W     = 58;
  localparam int MLT_W     = 26;
  localparam int DVS_W     = 25;
  localparam int MUL_STEPS = 26;
  localparam int DIV_STEPS = 58;
  localparam int CNT_W     = 6;

  // Offset and crop arithmetic.
  localparam int SUM_W   = 49;
  localparam int WHOLE_W = SUM_W - FRAC_BITS;
  localparam int TOP_W   = WHOLE_W + 1;

  localparam logic [16:0] CROP_MAX  = 17'h1FFFF;
  localparam logic [17:0] TOTAL_MAX = 18'h3FFFF;

  localparam logic [2:0] REG_TOTAL_DISTANCE   = 3'd0;
  localparam logic [2:0] REG_SCROLL_SPEED     = 3'd1;
  localparam logic [2:0] REG_RAMP_UP_FRAMES   = 3'd2;
  localparam logic [2:0] REG_RAMP_DOWN_FRAMES = 3'd3;
  localparam logic [2:0] REG_RAMP_UP_ON       = 3'd4;
  localparam logic [2:0] REG_RAMP_DOWN_ON     = 3'd5;
  localparam logic [2:0] REG_FIRST_ROW        = 3'd6;

  localparam logic [1:0] PH_ACCEL  = 2'd0;
  localparam logic [1:0] PH_LINEAR = 2'd1;
  localparam logic [1:0] PH_DECEL  = 2'd2;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } tso_op_t;

  typedef struct packed {
    logic    start;
    tso_op_t op;
  } tso_cmd_t;

  typedef enum logic [3:0] {
    ST_D_START,
    ST_D_MUL1,
    ST_D_MUL2,
    ST_D_DIVU,
    ST_D_DIVD,
    ST_D_DIVC,
    ST_D_FIN,
    ST_IDLE,
    ST_PHASE,
    ST_MSTART,
    ST_MWAIT,
    ST_VEL,
    ST_SUM,
    ST_OUT
  } tso_state_t;

endpackage

`default_nettype wire

@@ rtl/tso_serial.sv @@
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// Depends on tso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tso_serial (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tso_pkg::tso_cmd_t        cmd,
  input  wire logic [tso_pkg::OPA_W-1:0] opa,
  input  wire logic [tso_pkg::OPB_W-1:0] opb,
  output logic                          done,
  output logic [tso_pkg::OPB_W-1:0]     res
);

  logic                          busy_r;
  logic                          done_r;
  logic [tso_pkg::CNT_W-1:0]     cnt_r;
  tso_pkg::tso_op_t              op_r;
  logic [tso_pkg::OPA_W-1:0]     opa_r;
  logic [tso_pkg::OPA_W:0]       acc_r;
  logic [tso_pkg::OPB_W-1:0]     sh_r;

  logic [tso_pkg::OPA_W:0]       mul_sum;
  logic [tso_pkg::DVS_W:0]       dv_trial;
  logic [tso_pkg::DVS_W+1:0]     dv_diff;
  logic                          dv_ge;

  always_comb begin
    mul_sum  = acc_r + {1'b0, (sh_r[0] ? opa_r : {tso_pkg::OPA_W{1'b0}})};
    dv_trial = {acc_r[tso_pkg::DVS_W-1:0], sh_r[tso_pkg::OPB_W-1]};
    dv_diff  = {1'b0, dv_trial} - {2'b00, opa_r[tso_pkg::DVS_W-1:0]};
    dv_ge    = ~dv_diff[tso_pkg::DVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= tso_pkg::OP_MUL;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      op_r   <= cmd.op;
      cnt_r  <= (cmd.op == tso_pkg::OP_MUL) ? tso_pkg::CNT_W'(tso_pkg::MUL_STEPS - 1)
                                            : tso_pkg::CNT_W'(tso_pkg::DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
      sh_r  <= opb;
      opa_r <= opa;
    end else if (busy_r) begin
      if (op_r == tso_pkg::OP_MUL) begin
        acc_r <= {1'b0, mul_sum[tso_pkg::OPA_W:1]};
        sh_r  <= {sh_r[tso_pkg::OPB_W-1:tso_pkg::MLT_W], mul_sum[0],
                  sh_r[tso_pkg::MLT_W-1:1]};
      end else begin
        acc_r <= {{(tso_pkg::OPA_W - tso_pkg::DVS_W){1'b0}},
                  (dv_ge ? dv_diff[tso_pkg::DVS_W:0] : dv_trial)};
        sh_r  <= {sh_r[tso_pkg::OPB_W-2:0], dv_ge};
      end
    end
  end

  assign done = done_r;
  assign res  = (op_r == tso_pkg::OP_MUL) ?
                {acc_r[tso_pkg::OPA_W-1:0], sh_r[tso_pkg::MLT_W-1:0]} : sh_r;

endmodule

`default_nettype wire

@@ rtl/trapezoid_scroll_offset_top.sv @@
// Trapezoidal scroll offset generator: config registers, sequencer and offset accumulator.
// Depends on tso_pkg and tso_serial.
// A ramp frame steps through PHASE, MSTART, MWAIT, VEL, SUM and OUT after the accept;
// a linear frame skips MSTART and MWAIT. Words are taken only in IDLE, after OUT is free.
// Reset and every register write rederive the slopes and cruise length with
// in_tready low. Reset is synchronous and active low; it restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module trapezoid_scroll_offset_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] frame_time
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [16:0] crop_top, [18:17] phase,
                                       // [36:19] frame_total, [37] setup_error
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);

  tso_pkg::tso_state_t state_r, state_nxt;

  logic [15:0] total_distance_r;
  logic [23:0] scroll_speed_r;
  logic [15:0] ramp_up_frames_r;
  logic [15:0] ramp_down_frames_r;
  logic        ramp_up_on_r;
  logic        ramp_down_on_r;
  logic [15:0] first_row_r;

  logic signed [42:0] d2_r;
  logic [31:0]        up_slope_r;
  logic [31:0]        down_slope_r;
  logic signed [49:0] cruise_r;
  logic [17:0]        frame_total_r;
  logic               setup_error_r;

  logic signed [47:0] offset_r;
  logic [15:0]        t_r;
  logic [1:0]         phase_r;
  logic [24:0]        relq_r;
  logic signed [42:0] v_r;

  logic        out_valid_r;
  logic [39:0] out_data_r;

  tso_pkg::tso_cmd_t           unit_cmd;
  logic [tso_pkg::OPA_W-1:0]   unit_a;
  logic [tso_pkg::OPB_W-1:0]   unit_b;
  logic                        unit_done;
  logic [tso_pkg::OPB_W-1:0]   unit_res;

  logic        cfg_hit;
  logic        in_acc;
  logic        out_free;
  logic [23:0] spd_div;
  logic [15:0] up_div;
  logic [15:0] dn_div;
  logic        d2_neg;
  logic [42:0] d2_abs;
  logic signed [49:0] cruise_calc;
  logic signed [50:0] knee;
  logic signed [50:0] rel;
  logic [1:0]  phase_sel;
  logic signed [42:0] v_calc;
  logic signed [48:0] sum_ext;
  logic signed [47:0] sum_sat;
  logic [tso_pkg::SUM_W-1:0]   rnd;
  logic [tso_pkg::WHOLE_W-1:0] whole;
  logic signed [tso_pkg::TOP_W-1:0] top;
  logic [16:0] crop_calc;
  logic [16:0] ramp_sum;
  logic signed [50:0] ft_sum;
  logic [33:0] ft_whole;
  logic [17:0] ft_calc;
  logic signed [17:0] dist_left;
  logic        err_calc;

  tso_serial u_serial (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (unit_cmd),
    .opa   (unit_a),
    .opb   (unit_b),
    .done  (unit_done),
    .res   (unit_res)
  );

  assign cfg_hit   = cfg_wr_en && (cfg_index <= tso_pkg::REG_FIRST_ROW);
  assign in_tready = (state_r == tso_pkg::ST_IDLE) && !cfg_wr_en;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    spd_div = (scroll_speed_r == '0) ? 24'd1 : scroll_speed_r;
    up_div  = (ramp_up_frames_r == '0) ? 16'd1 : ramp_up_frames_r;
    dn_div  = (ramp_down_frames_r == '0) ? 16'd1 : ramp_down_frames_r;
    d2_neg  = d2_r[42];
    d2_abs  = d2_neg ? 43'(-d2_r) : 43'(d2_r);
    cruise_calc = d2_neg ? -$signed({1'b0, unit_res[48:0]})
                         :  $signed({1'b0, unit_res[48:0]});

    knee = $signed({cruise_r[49], cruise_r}) + $signed({19'b0, ramp_up_frames_r, 16'b0});
    rel  = $signed({19'b0, t_r, 16'b0}) - knee;
    if (ramp_up_on_r && (t_r <= ramp_up_frames_r)) begin
      phase_sel = tso_pkg::PH_ACCEL;
    end else if (ramp_down_on_r && !rel[50] && (rel[49:0] != '0)) begin
      phase_sel = tso_pkg::PH_DECEL;
    end else begin
      phase_sel = tso_pkg::PH_LINEAR;
    end

    case (phase_r)
      tso_pkg::PH_ACCEL: v_calc = $signed({3'b0, unit_res[47:8]});
      tso_pkg::PH_DECEL: v_calc = $signed({19'b0, scroll_speed_r})
                                - $signed({1'b0, unit_res[57:16]});
      default:           v_calc = $signed({19'b0, scroll_speed_r});
    endcase

    sum_ext = $signed({offset_r[47], offset_r}) + $signed({{6{v_r[42]}}, v_r});
    if (sum_ext[48] != sum_ext[47]) begin
      sum_sat = sum_ext[48] ? $signed({1'b1, 47'b0}) : $signed({1'b0, {47{1'b1}}});
    end else begin
      sum_sat = sum_ext[47:0];
    end

    rnd   = {offset_r[47], offset_r}
          + (offset_r[47] ? {{(tso_pkg::SUM_W - tso_pkg::FRAC_BITS){1'b0}},
                             {tso_pkg::FRAC_BITS{1'b1}}}
                          : {tso_pkg::SUM_W{1'b0}});
    whole = rnd[tso_pkg::SUM_W-1:tso_pkg::FRAC_BITS];
    top   = $signed({whole[tso_pkg::WHOLE_W-1], whole})
          + $signed({{(tso_pkg::TOP_W - 16){1'b0}}, first_row_r});
    if (top[tso_pkg::TOP_W-1]) begin
      crop_calc = '0;
    end else if (top[tso_pkg::TOP_W-2:17] != '0) begin
      crop_calc = tso_pkg::CROP_MAX;
    end else begin
      crop_calc = top[16:0];
    end

    ramp_sum = {1'b0, ramp_up_frames_r} + {1'b0, ramp_down_frames_r};
    ft_sum   = $signed({cruise_r[49], cruise_r}) + $signed({18'b0, ramp_sum, 16'b0});
    ft_whole = ft_sum[49:16];
    if (ft_sum[50]) begin
      ft_calc = '0;
    end else if (ft_whole[33:18] != '0) begin
      ft_calc = tso_pkg::TOTAL_MAX;
    end else begin
      ft_calc = ft_whole[17:0];
    end

    dist_left = $signed({2'b0, total_distance_r}) - $signed({2'b0, ramp_up_frames_r});
    err_calc  = dist_left < $signed({2'b0, ramp_down_frames_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tso_pkg::ST_D_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    unit_cmd.start = 1'b0;
    unit_cmd.op    = tso_pkg::OP_MUL;
    unit_a         = '0;
    unit_b         = '0;
    unique case (state_r)
      tso_pkg::ST_D_START: begin
        unit_cmd.start = 1'b1;
        unit_a         = {8'b0, scroll_speed_r};
        unit_b         = {42'b0, ramp_up_frames_r};
        state_nxt      = tso_pkg::ST_D_MUL1;
      end
      tso_pkg::ST_D_MUL1: begin
        if (unit_done) begin
          unit_cmd.start = 1'b1;
          unit_a         = {8'b0, scroll_speed_r};
          unit_b         = {42'b0, ramp_down_frames_r};
          state_nxt      = tso_pkg::ST_D_MUL2;
        end
      end
      tso_pkg::ST_D_MUL2: begin
        if (unit_done) begin
          unit_cmd.start = 1'b1;
          unit_cmd.op    = tso_pkg::OP_DIV;
          unit_a         = {16'b0, up_div};
          unit_b         = {26'b0, scroll_speed_r, 8'b0};
          state_nxt      = tso_pkg::ST_D_DIVU;
        end
      end
      tso_pkg::ST_D_DIVU: begin
        if (unit_done) begin
          unit_cmd.start = 1'b1;
          unit_cmd.op    = tso_pkg::OP_DIV;
          unit_a         = {16'b0, dn_div};
          unit_b         = {26'b0, scroll_speed_r, 8'b0};
          state_nxt      = tso_pkg::ST_D_DIVD;
        end
      end
      tso_pkg::ST_D_DIVD: begin
        if (unit_done) begin
          unit_cmd.start = 1'b1;
          unit_cmd.op    = tso_pkg::OP_DIV;
          unit_a         = {7'b0, spd_div, 1'b0};
          unit_b         = {d2_abs[41:0], 16'b0};
          state_nxt      = tso_pkg::ST_D_DIVC;
        end
      end
      tso_pkg::ST_D_DIVC: begin
        if (unit_done) begin
          state_nxt = tso_pkg::ST_D_FIN;
        end
      end
      tso_pkg::ST_D_FIN: begin
        state_nxt = tso_pkg::ST_IDLE;
      end
      tso_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = tso_pkg::ST_PHASE;
        end
      end
      tso_pkg::ST_PHASE: begin
        state_nxt = (phase_sel == tso_pkg::PH_LINEAR) ? tso_pkg::ST_VEL
                                                      : tso_pkg::ST_MSTART;
      end
      tso_pkg::ST_MSTART: begin
        unit_cmd.start = 1'b1;
        if (phase_r == tso_pkg::PH_ACCEL) begin
          unit_a = up_slope_r;
          unit_b = {42'b0, t_r};
        end else begin
          unit_a = down_slope_r;
          unit_b = {33'b0, relq_r};
        end
        state_nxt = tso_pkg::ST_MWAIT;
      end
      tso_pkg::ST_MWAIT: begin
        if (unit_done) begin
          state_nxt = tso_pkg::ST_VEL;
        end
      end
      tso_pkg::ST_VEL: begin
        state_nxt = tso_pkg::ST_SUM;
      end
      tso_pkg::ST_SUM: begin
        state_nxt = tso_pkg::ST_OUT;
      end
      tso_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = tso_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tso_pkg::ST_D_START;
      end
    endcase
    if (cfg_hit) begin
      state_nxt = tso_pkg::ST_D_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_distance_r   <= 16'd0;
      scroll_speed_r     <= 24'd65536;
      ramp_up_frames_r   <= 16'd1;
      ramp_down_frames_r <= 16'd1;
      ramp_up_on_r       <= 1'b0;
      ramp_down_on_r     <= 1'b0;
      first_row_r        <= 16'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tso_pkg::REG_TOTAL_DISTANCE:   total_distance_r   <= cfg_wdata[15:0];
        tso_pkg::REG_SCROLL_SPEED:     scroll_speed_r     <= cfg_wdata;
        tso_pkg::REG_RAMP_UP_FRAMES:   ramp_up_frames_r   <= cfg_wdata[15:0];
        tso_pkg::REG_RAMP_DOWN_FRAMES: ramp_down_frames_r <= cfg_wdata[15:0];
        tso_pkg::REG_RAMP_UP_ON:       ramp_up_on_r       <= cfg_wdata[0];
        tso_pkg::REG_RAMP_DOWN_ON:     ramp_down_on_r     <= cfg_wdata[0];
        tso_pkg::REG_FIRST_ROW:        first_row_r        <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_hit) begin
      offset_r <= '0;
    end else if (state_r == tso_pkg::ST_SUM) begin
      offset_r <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      tso_pkg::ST_D_START: begin
        d2_r <= $signed({10'b0, total_distance_r, 17'b0});
      end
      tso_pkg::ST_D_MUL1: begin
        if (unit_done && ramp_up_on_r) begin
          d2_r <= d2_r - $signed({3'b0, unit_res[39:0]});
        end
      end
      tso_pkg::ST_D_MUL2: begin
        if (unit_done && ramp_down_on_r) begin
          d2_r <= d2_r - $signed({3'b0, unit_res[39:0]});
        end
      end
      tso_pkg::ST_D_DIVU: begin
        if (unit_done) begin
          up_slope_r <= ramp_up_on_r ? unit_res[31:0] : 32'd0;
        end
      end
      tso_pkg::ST_D_DIVD: begin
        if (unit_done) begin
          down_slope_r <= ramp_down_on_r ? unit_res[31:0] : 32'd0;
        end
      end
      tso_pkg::ST_D_DIVC: begin
        if (unit_done) begin
          cruise_r <= cruise_calc;
        end
      end
      tso_pkg::ST_D_FIN: begin
        frame_total_r <= ft_calc;
        setup_error_r <= err_calc;
      end
      tso_pkg::ST_IDLE: begin
        if (in_acc) begin
          t_r <= in_tdata;
        end
      end
      tso_pkg::ST_PHASE: begin
        phase_r <= phase_sel;
        relq_r  <= rel[32:8];
      end
      tso_pkg::ST_VEL: begin
        v_r <= v_calc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == tso_pkg::ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == tso_pkg::ST_OUT) && out_free) begin
      out_data_r <= {2'b00, setup_error_r, frame_total_r, phase_r, crop_calc};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
